// ----- rtl/neo_hookean_first_piola_stress_unit_assert.svh -----
// Assertion macros shared by the stress unit RTL.
`ifndef NEO_HOOKEAN_FIRST_PIOLA_STRESS_UNIT_ASSERT_SVH
`define NEO_HOOKEAN_FIRST_PIOLA_STRESS_UNIT_ASSERT_SVH

// Next-cycle implication, disabled while reset is high.
`define NHPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("stress unit assertion failed");

// Next-cycle implication that also holds across reset.
`define NHPS_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("stress unit assertion failed");

`endif

// ----- rtl/nhps_pkg.sv -----
// Shared widths and register codes for the stress unit.
package nhps_pkg;
   localparam int F_W     = 32;
   localparam int P_W     = 64;
   localparam int MU_W    = 40;
   localparam int ALPHA_W = 32;
   localparam int COF_W   = 65;
   localparam int Q_W     = 66;
   localparam int FC_W    = F_W + COF_W;
   localparam int D_W     = 98;
   localparam int MUF_W   = MU_W + 1 + F_W;
   localparam int MAG_W   = MUF_W - 1;
   localparam int LD_W    = MU_W + 1 + D_W;
   localparam int B_W     = LD_W + COF_W;
   localparam int MUL_LAT = 5;

   typedef enum logic [1:0] {
      CSR_SHEAR  = 2'd0,
      CSR_VOLUME = 2'd1,
      CSR_ALPHA  = 2'd2
   } csr_index_type;
endpackage

// ----- rtl/nhps_delay.sv -----
// Enabled shift register that aligns data between pipeline paths.
module nhps_delay #(
   parameter int W = 8,
   parameter int N = 1
) (
   input  logic         clock,
   input  logic         en,
   input  logic [W-1:0] d,
   output logic [W-1:0] q
);
   logic [W-1:0] sr_ff [N];

   always_ff @(posedge clock) begin
      if (en) begin
         sr_ff[0] <= d;
         for (int i = 1; i < N; i++) begin
            sr_ff[i] <= sr_ff[i-1];
         end
      end
   end

   assign q = sr_ff[N-1];
endmodule

// ----- rtl/nhps_mul.sv -----
// Pipelined signed multiplier built from 32 by 32 partial products.
module nhps_mul #(
   parameter int WA = 32,
   parameter int WB = 32
) (
   input  logic                    clock,
   input  logic                    en,
   input  logic signed [WA-1:0]    a,
   input  logic signed [WB-1:0]    b,
   output logic signed [WA+WB-1:0] p
);
   localparam int NA = (WA + 31) / 32;
   localparam int NB = (WB + 31) / 32;
   localparam int WP = 32 * (NA + NB);
   localparam int WO = WA + WB;

   logic [3:0]        sg_ff;
   logic [WA-1:0]     ma_ff;
   logic [WB-1:0]     mb_ff;
   logic [32*NA-1:0]  ma_pad;
   logic [32*NB-1:0]  mb_pad;
   logic [63:0]       pp_in [NA][NB];
   logic [63:0]       pp_ff [NA][NB];
   logic [WP-1:0]     row_in [NA];
   logic [WP-1:0]     row_ff [NA];
   logic [WP-1:0]     tot_in;
   logic [WP-1:0]     tot_ff;
   logic signed [WO-1:0] p_ff;

   assign ma_pad = (32*NA)'(ma_ff);
   assign mb_pad = (32*NB)'(mb_ff);

   always_comb begin
      for (int i = 0; i < NA; i++) begin
         for (int j = 0; j < NB; j++) begin
            pp_in[i][j] = ma_pad[32*i +: 32] * mb_pad[32*j +: 32];
         end
      end
      for (int i = 0; i < NA; i++) begin
         row_in[i] = '0;
         for (int j = 0; j < NB; j++) begin
            row_in[i] = row_in[i] + (WP'(pp_ff[i][j]) << (32*j));
         end
      end
      tot_in = '0;
      for (int i = 0; i < NA; i++) begin
         tot_in = tot_in + (row_ff[i] << (32*i));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sg_ff <= {sg_ff[2:0], a[WA-1] ^ b[WB-1]};
         ma_ff <= a[WA-1] ? WA'(-a) : WA'(a);
         mb_ff <= b[WB-1] ? WB'(-b) : WB'(b);
         pp_ff <= pp_in;
         row_ff <= row_in;
         tot_ff <= tot_in;
         p_ff <= sg_ff[3] ? -$signed(tot_ff[WO-1:0]) : $signed(tot_ff[WO-1:0]);
      end
   end

   assign p = p_ff;
endmodule

// ----- rtl/nhps_div.sv -----
// Restoring divider pipeline, one quotient bit per stage.
module nhps_div import nhps_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                         clock,
   input  logic                         en,
   input  logic [MAG_W-1:0]             mag,
   input  logic [Q_W-1:0]               den,
   output logic [39+5*FRAC_BITS-1:0]    quo
);
   localparam int QW  = 39 + 5 * FRAC_BITS;
   localparam int NSH = 6 * FRAC_BITS;

   logic [Q_W-1:0]   rem_ff [QW+1];
   logic [MAG_W-1:0] mag_ff [QW+1];
   logic [Q_W-1:0]   den_ff [QW+1];
   logic [QW-1:0]    quo_ff [QW+1];

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= Q_W'(mag >> (QW - NSH));
         mag_ff[0] <= mag;
         den_ff[0] <= den;
         quo_ff[0] <= '0;
      end
   end

   for (genvar k = 1; k <= QW; k++) begin : g_stage
      localparam int P = QW - k;
      logic          nbit;
      logic [Q_W:0]  trial;
      logic          take;
      logic [QW-1:0] quo_in;

      if (P >= NSH) begin : g_bit
         assign nbit = mag_ff[k-1][P-NSH];
      end else begin : g_zero
         assign nbit = 1'b0;
      end

      always_comb begin
         trial = {rem_ff[k-1], nbit};
         take = trial >= {1'b0, den_ff[k-1]};
         quo_in = quo_ff[k-1];
         quo_in[P] = take;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= take ? Q_W'(trial - {1'b0, den_ff[k-1]}) : Q_W'(trial);
            mag_ff[k] <= mag_ff[k-1];
            den_ff[k] <= den_ff[k-1];
            quo_ff[k] <= quo_in;
         end
      end
   end

   assign quo = quo_ff[QW];
endmodule

// ----- rtl/neo_hookean_first_piola_stress_unit.sv -----
// Top level of the stable Neo-Hookean first Piola stress pipeline.
//
// One deformation gradient F enters per req beat: nine signed fixed-point
// entries, row-major, f00 in the lowest 32 bits of req_tdata. One rsp beat
// carries the nine saturated stress entries, p00 in the lowest 64 bits of
// rsp_tdata, and the saturation flag in rsp_tuser.
// The csr channel loads mu, lambda and alpha; it is ready whenever reset is
// low. The user must see that it is written only while the pipeline is
// empty; the block does not enforce this. Throughput is one matrix per
// cycle while the output does not stall. The restoring divider forms
// mu*|f|/(Ic+1) one quotient bit per stage.
// The whole pipeline advances together: when rsp_tvalid is high and
// rsp_tready is low, every stage holds and req_tready drops, so no beat is
// lost or repeated. Reset empties the pipeline, holds both ready outputs low
// and restores the register defaults of mu = 1.0, lambda = 1.0 and
// alpha = 1.75.
module neo_hookean_first_piola_stress_unit import nhps_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // f00, f01, f02, f10, f11, f12, f20, f21, f22 from the lowest bit up
   input  logic [9*F_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // p00, p01, p02, p10, p11, p12, p20, p21, p22 from the lowest bit up
   output logic [9*P_W-1:0] rsp_tdata,
   // overflow_flag
   output logic [0:0]       rsp_tuser,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [MU_W-1:0]  csr_data
);
   localparam int QW  = 39 + 5 * FRAC_BITS;
   localparam int SC  = QW + 6;
   localparam int LAT = SC + 3;
   localparam int WS  = 208;

   logic               en;
   logic [LAT:0]       valid_ff;
   logic [MU_W-1:0]    mu_ff;
   logic [MU_W-1:0]    lam_ff;
   logic [ALPHA_W-1:0] alpha_ff;

   logic signed [F_W-1:0]   f_ff   [9];
   logic signed [63:0]      pa_ff  [9];
   logic signed [63:0]      pb_ff  [9];
   logic [63:0]             sq_ff  [9];
   logic signed [COF_W-1:0] cof_ff [9];
   logic [64:0]             icp_ff [3];
   logic [Q_W-1:0]          q_ff;
   logic [Q_W-1:0]          q_d;
   logic signed [FC_W-1:0]  fc     [3];
   logic signed [D_W-1:0]   d_in;
   logic signed [D_W-1:0]   d_ff;
   logic signed [LD_W-1:0]  ld;
   logic signed [P_W-1:0]   p_ff   [9];
   logic [8:0]              sat;
   logic                    ovf_ff;

   assign en = !valid_ff[LAT] || rsp_tready;
   assign req_tready = en && !reset;
   assign rsp_tvalid = valid_ff[LAT];
   assign csr_ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         mu_ff <= MU_W'(65536);
         lam_ff <= MU_W'(65536);
         alpha_ff <= ALPHA_W'(114688);
      end else begin
         if (en) begin
            valid_ff <= {valid_ff[LAT-1:0], req_tvalid};
         end
         if (csr_valid) begin
            if (csr_index == CSR_SHEAR) begin
               mu_ff <= csr_data;
            end else if (csr_index == CSR_VOLUME) begin
               lam_ff <= csr_data;
            end else if (csr_index == CSR_ALPHA) begin
               alpha_ff <= csr_data[ALPHA_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 9; k++) begin
            f_ff[k] <= $signed(req_tdata[F_W*k +: F_W]);
            sq_ff[k] <= 64'(f_ff[k] * f_ff[k]);
            cof_ff[k] <= COF_W'(pa_ff[k]) - COF_W'(pb_ff[k]);
         end
         for (int r = 0; r < 3; r++) begin
            icp_ff[r] <= 65'(sq_ff[3*r]) + 65'(sq_ff[3*r+1]) + 65'(sq_ff[3*r+2]);
         end
         q_ff <= 66'(icp_ff[0]) + 66'(icp_ff[1]) + 66'(icp_ff[2])
                 + (66'(1) << (2 * FRAC_BITS));
         d_ff <= d_in;
      end
   end

   for (genvar i = 0; i < 3; i++) begin : g_row
      for (genvar j = 0; j < 3; j++) begin : g_col
         localparam int R1 = (i + 1) % 3;
         localparam int R2 = (i + 2) % 3;
         localparam int C1 = (j + 1) % 3;
         localparam int C2 = (j + 2) % 3;
         always_ff @(posedge clock) begin
            if (en) begin
               pa_ff[i*3+j] <= f_ff[R1*3+C1] * f_ff[R2*3+C2];
               pb_ff[i*3+j] <= f_ff[R1*3+C2] * f_ff[R2*3+C1];
            end
         end
      end
   end

   nhps_delay #(.W(Q_W), .N(2)) u_q_dly (
      .clock(clock), .en(en), .d(q_ff), .q(q_d)
   );

   for (genvar k = 0; k < 3; k++) begin : g_det
      logic [F_W-1:0] fd;
      nhps_delay #(.W(F_W), .N(2)) u_f_dly (
         .clock(clock), .en(en), .d(f_ff[k]), .q(fd)
      );
      nhps_mul #(.WA(F_W), .WB(COF_W)) u_fc (
         .clock(clock), .en(en), .a($signed(fd)), .b(cof_ff[k]), .p(fc[k])
      );
   end

   assign d_in = D_W'(fc[0]) + D_W'(fc[1]) + D_W'(fc[2])
                 - $signed(D_W'(alpha_ff) << (2 * FRAC_BITS));

   nhps_mul #(.WA(MU_W + 1), .WB(D_W)) u_ld (
      .clock(clock), .en(en), .a($signed({1'b0, lam_ff})), .b(d_ff), .p(ld)
   );

   for (genvar k = 0; k < 9; k++) begin : g_lane
      logic signed [MUF_W-1:0] muf;
      logic [MAG_W-1:0]        mag;
      logic [QW-1:0]           quo;
      logic [COF_W-1:0]        cof_d;
      logic signed [B_W-1:0]   bt;
      logic [MUF_W-1:0]        muf_d;
      logic [B_W-1:0]          bt_d;
      logic signed [WS-1:0]    a_val;
      logic signed [WS-1:0]    c_val;
      logic signed [WS-1:0]    ac_in;
      logic signed [WS-1:0]    ac_ff;
      logic signed [WS-1:0]    bh_ff;
      logic signed [WS-1:0]    s_ff;
      logic signed [WS-1:0]    sh;
      logic                    hi_ok;

      nhps_mul #(.WA(MU_W + 1), .WB(F_W)) u_muf (
         .clock(clock), .en(en), .a($signed({1'b0, mu_ff})), .b(f_ff[k]), .p(muf)
      );

      assign mag = muf[MUF_W-1] ? MAG_W'(-muf) : MAG_W'(muf);

      nhps_div #(.FRAC_BITS(FRAC_BITS)) u_div (
         .clock(clock), .en(en), .mag(mag), .den(q_d), .quo(quo)
      );

      nhps_delay #(.W(COF_W), .N(11)) u_cof_dly (
         .clock(clock), .en(en), .d(cof_ff[k]), .q(cof_d)
      );

      nhps_mul #(.WA(LD_W), .WB(COF_W)) u_b (
         .clock(clock), .en(en), .a(ld), .b($signed(cof_d)), .p(bt)
      );

      nhps_delay #(.W(MUF_W), .N(QW + 1)) u_muf_dly (
         .clock(clock), .en(en), .d(muf), .q(muf_d)
      );

      nhps_delay #(.W(B_W), .N(QW - 12)) u_b_dly (
         .clock(clock), .en(en), .d(bt), .q(bt_d)
      );

      always_comb begin
         a_val = WS'($signed(muf_d)) <<< (4 * FRAC_BITS);
         c_val = $signed(WS'(quo));
         ac_in = muf_d[MUF_W-1] ? a_val + c_val : a_val - c_val;
         sh = s_ff >>> (5 * FRAC_BITS);
         hi_ok = sh[WS-1:P_W-1] == {(WS-P_W+1){sh[P_W-1]}};
         sat[k] = !hi_ok;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            ac_ff <= ac_in;
            bh_ff <= WS'($signed(bt_d)) + $signed(WS'(1) << (5 * FRAC_BITS - 1));
            s_ff <= ac_ff + bh_ff;
            if (hi_ok) begin
               p_ff[k] <= sh[P_W-1:0];
            end else if (sh[WS-1]) begin
               p_ff[k] <= {1'b1, {(P_W-1){1'b0}}};
            end else begin
               p_ff[k] <= {1'b0, {(P_W-1){1'b1}}};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ovf_ff <= |sat;
      end
   end

   always_comb begin
      for (int k = 0; k < 9; k++) begin
         rsp_tdata[P_W*k +: P_W] = p_ff[k];
      end
   end

   assign rsp_tuser[0] = ovf_ff;

`include "neo_hookean_first_piola_stress_unit_assert.svh"

   `NHPS_ASSERT_NEXT_ALWAYS(a_reset_empties, clock, reset, !rsp_tvalid && valid_ff == '0)
   `NHPS_ASSERT_NEXT(a_accept_enters, clock, reset, req_tvalid && req_tready, valid_ff[0])
   `NHPS_ASSERT_NEXT(a_stall_holds, clock, reset, !en, $stable(valid_ff))
endmodule
